>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
// Shared codes for the rational arithmetic unit: operation kinds, error codes
// and compare results. No dependencies.
package rau_pkg;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_NEG  = 3'd4;
    localparam logic [2:0] KIND_INC  = 3'd5;
    localparam logic [2:0] KIND_CMP  = 3'd6;
    localparam logic [2:0] KIND_NONE = 3'd7;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ZDEN = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    localparam logic [1:0] ORD_LESS    = 2'b11;
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_GREATER = 2'b01;

endpackage

>>> rtl/rau_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the rational arithmetic unit top level.
module rau_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         go,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: sequencer, shared multiplier,
// binary gcd and result formatting. Depends on rau_pkg and rau_div.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+------------------------------------
//  command   | start, busy (taken when  | kind, a_num, a_den, b_num, b_den
//            | start & !busy)           |
//  result    | done (one-cycle strobe)  | res_num, res_den, order, error
//
// An item whose outcome is known at once (zero denominator, divide by zero,
// unused kind) gives its result in the cycle after it is taken. A compare
// passes through the multiply and combine states. A fraction result goes on
// through the binary gcd and two runs of the shared divider, one bit a
// cycle; zero results skip the gcd and divider. For other items busy is high
// from the cycle after start until the result is shown; a new item may be
// started in the cycle done is high. The receiver cannot stall; results are
// not held back. Reset clears the sequencer only.
module rational_arithmetic_unit_core #(
    parameter int WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic [31:0] res_num,
    output logic [30:0] res_den,
    output logic [1:0]  order,
    output logic [1:0]  error,
    output logic        done
);
    localparam int LW = 2 * WIDTH;
    localparam int KW = $clog2(LW);
    localparam logic [LW-1:0] LIM = LW'(1) << (WIDTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_COMB = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIVN = 3'd4;
    localparam logic [2:0] S_DIVD = 3'd5;

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
        return x[WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

    logic [2:0]       state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic             a_neg_reg, a_neg_next;
    logic             b_neg_reg, b_neg_next;
    logic [WIDTH-1:0] am_reg, am_next, ad_reg, ad_next;
    logic [WIDTH-1:0] bm_reg, bm_next, bd_reg, bd_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [LW-1:0]    p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic             rneg_reg, rneg_next;
    logic [LW-1:0]    u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [31:0]      res_num_reg, res_num_next;
    logic [30:0]      res_den_reg, res_den_next;
    logic [1:0]       order_reg, order_next;
    logic [1:0]       error_reg, error_next;
    logic             done_reg, done_next;

    logic [WIDTH-1:0] mx, my;
    logic [LW-1:0]    prod;
    logic             div_go, div_done;
    logic [LW-1:0]    div_dividend, div_divisor, div_q;

    logic             in_uses_b, sq, s_neg, ovf;
    logic [LW-1:0]    s_mag, r_num, r_den, qn, qd;
    logic [LW:0]      cmp_l, cmp_r;
    logic [WIDTH-1:0] num_w;

    rau_div #(.W(LW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared multiplier operand select: step 0 numerator, 1 cross term,
    // 2 denominator. Negate and increment multiply by one (negate keeps the step 1 cross term).
    always_comb
    begin
        mx = am_reg;
        my = bd_reg;
        case (cnt_reg)
            2'd0:
            begin
                mx = am_reg;
                if (kind_reg == rau_pkg::KIND_MUL)
                    my = bm_reg;
                else if (kind_reg == rau_pkg::KIND_NEG || kind_reg == rau_pkg::KIND_INC)
                    my = WIDTH'(1);
                else
                    my = bd_reg;
            end
            2'd1:
            begin
                if (kind_reg == rau_pkg::KIND_INC)
                begin
                    mx = ad_reg;
                    my = WIDTH'(1);
                end
                else
                begin
                    mx = bm_reg;
                    my = ad_reg;
                end
            end
            default:
            begin
                mx = ad_reg;
                if (kind_reg == rau_pkg::KIND_DIV)
                    my = bm_reg;
                else if (kind_reg == rau_pkg::KIND_NEG || kind_reg == rau_pkg::KIND_INC)
                    my = WIDTH'(1);
                else
                    my = bd_reg;
            end
        endcase
        prod = LW'(mx) * LW'(my);
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        a_neg_next   = a_neg_reg;
        b_neg_next   = b_neg_reg;
        am_next      = am_reg;
        ad_next      = ad_reg;
        bm_next      = bm_reg;
        bd_next      = bd_reg;
        cnt_next     = cnt_reg;
        p0_next      = p0_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        rneg_next    = rneg_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        g_next       = g_reg;
        k_next       = k_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        order_next   = order_reg;
        error_next   = error_reg;
        done_next    = 1'b0;
        div_go       = 1'b0;
        div_dividend = p0_reg;
        div_divisor  = g_reg;

        in_uses_b = (kind == rau_pkg::KIND_ADD) || (kind == rau_pkg::KIND_SUB)
                 || (kind == rau_pkg::KIND_MUL) || (kind == rau_pkg::KIND_DIV)
                 || (kind == rau_pkg::KIND_CMP);

        // signed sum of the two cross terms (add, subtract, increment)
        if (kind_reg == rau_pkg::KIND_SUB)
            sq = !b_neg_reg;
        else if (kind_reg == rau_pkg::KIND_INC)
            sq = 1'b0;
        else
            sq = b_neg_reg;
        if (a_neg_reg == sq)
        begin
            s_neg = a_neg_reg;
            s_mag = p0_reg + p1_reg;
        end
        else if (p0_reg >= p1_reg)
        begin
            s_neg = a_neg_reg;
            s_mag = p0_reg - p1_reg;
        end
        else
        begin
            s_neg = sq;
            s_mag = p1_reg - p0_reg;
        end

        cmp_l = a_neg_reg ? -{1'b0, p0_reg} : {1'b0, p0_reg};
        cmp_r = b_neg_reg ? -{1'b0, p1_reg} : {1'b0, p1_reg};

        qn    = p1_reg;
        qd    = div_q;
        ovf   = (rneg_reg ? (qn > LIM) : (qn > LIM - 1'b1)) || (qd > LIM - 1'b1);
        num_w = rneg_reg ? (~qn[WIDTH-1:0] + 1'b1) : qn[WIDTH-1:0];
        r_num = p0_reg;
        r_den = p2_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    a_neg_next = a_num[WIDTH-1] ^ a_den[WIDTH-1];
                    b_neg_next = b_num[WIDTH-1] ^ b_den[WIDTH-1];
                    am_next    = mag(a_num[WIDTH-1:0]);
                    ad_next    = mag(a_den[WIDTH-1:0]);
                    bm_next    = mag(b_num[WIDTH-1:0]);
                    bd_next    = mag(b_den[WIDTH-1:0]);
                    cnt_next   = '0;
                    res_num_next = '0;
                    res_den_next = '0;
                    order_next   = rau_pkg::ORD_EQUAL;
                    error_next   = rau_pkg::ERR_NONE;
                    // settle trivial outcomes at once
                    if (kind == rau_pkg::KIND_NONE)
                        done_next = 1'b1;
                    else if (a_den[WIDTH-1:0] == '0
                             || (in_uses_b && b_den[WIDTH-1:0] == '0)
                             || (kind == rau_pkg::KIND_DIV && b_num[WIDTH-1:0] == '0))
                    begin
                        error_next = rau_pkg::ERR_ZDEN;
                        done_next  = 1'b1;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                case (cnt_reg)
                    2'd0:    p0_next = prod;
                    2'd1:    p1_next = prod;
                    default: p2_next = prod;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd2)
                    state_next = S_COMB;
            end
            S_COMB:
            begin
                if (kind_reg == rau_pkg::KIND_CMP)
                begin
                    if ($signed(cmp_l) < $signed(cmp_r))
                        order_next = rau_pkg::ORD_LESS;
                    else if ($signed(cmp_l) > $signed(cmp_r))
                        order_next = rau_pkg::ORD_GREATER;
                    else
                        order_next = rau_pkg::ORD_EQUAL;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    case (kind_reg)
                        rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_INC:
                        begin
                            rneg_next = s_neg;
                            r_num     = s_mag;
                        end
                        rau_pkg::KIND_NEG:
                            rneg_next = !a_neg_reg;
                        default:
                            rneg_next = a_neg_reg ^ b_neg_reg;
                    endcase
                    p0_next = r_num;
                    u_next  = r_num;
                    v_next  = r_den;
                    k_next  = '0;
                    if (r_num == '0)
                    begin
                        // zero is always 0/1
                        res_num_next = '0;
                        res_den_next = 31'd1;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                        state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (u_reg == '0 || v_reg == '0)
                begin
                    g_next       = (u_reg == '0 ? v_reg : u_reg) << k_reg;
                    div_go       = 1'b1;
                    div_dividend = p0_reg;
                    div_divisor  = g_next;
                    state_next   = S_DIVN;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_next = u_reg - v_reg;
                else
                    v_next = v_reg - u_reg;
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    p1_next      = div_q;
                    div_go       = 1'b1;
                    div_dividend = p2_reg;
                    div_divisor  = g_reg;
                    state_next   = S_DIVD;
                end
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    if (ovf)
                        error_next = rau_pkg::ERR_OVF;
                    else
                    begin
                        res_num_next = 32'(signed'(num_w));
                        res_den_next = 31'(qd[WIDTH-2:0]);
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        a_neg_reg   <= a_neg_next;
        b_neg_reg   <= b_neg_next;
        am_reg      <= am_next;
        ad_reg      <= ad_next;
        bm_reg      <= bm_next;
        bd_reg      <= bd_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        rneg_reg    <= rneg_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        g_reg       <= g_next;
        k_reg       <= k_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        order_reg   <= order_next;
        error_reg   <= error_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign order   = order_reg;
    assign error   = error_reg;

endmodule

>>> verif/rational_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rational_arithmetic_unit_core: a directed table
// followed by random items, all checked against an exact fraction predictor.
// Depends on rau_pkg and the RTL of the unit.
module rational_arithmetic_unit_core_tb;

    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  ord;
        logic [1:0]  err;
    } frac_result_t;

    typedef struct {
        logic [2:0]   op;
        logic [31:0]  an;
        logic [31:0]  ad;
        logic [31:0]  bn;
        logic [31:0]  bd;
        bit           typed;   // expected value given in the table
        frac_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [31:0] a_num, a_den, b_num, b_den;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  order;
    logic [1:0]  error;
    logic        done;

    frac_result_t pending_results[$];
    int          fail_count;
    int          cycle_count;
    bit          stim_done;

    rational_arithmetic_unit_core #(.WIDTH(32)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .res_num(res_num), .res_den(res_den), .order(order), .error(error),
        .done(done)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Euclid on magnitudes; operands fit 64 bits
    function automatic logic [63:0] gcd_mag(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Exact rational operation: magnitudes and signs kept apart, reduced at the end
    function automatic frac_result_t compute_fraction(logic [2:0] op, logic [31:0] an,
                                                      logic [31:0] ad, logic [31:0] bn,
                                                      logic [31:0] bd);
        frac_result_t r;
        logic signed [63:0] san, sad, sbn, sbd, lhs, rhs;
        logic [63:0] amag, adm, bmag, bdm, p, q, rn, rd, g;
        bit aneg, bneg, qneg, rneg, uses_b;
        san = $signed(an);
        sad = $signed(ad);
        sbn = $signed(bn);
        sbd = $signed(bd);
        aneg = (san < 0) != (sad < 0);
        bneg = (sbn < 0) != (sbd < 0);
        amag = san < 0 ? -san : san;
        adm  = sad < 0 ? -sad : sad;
        bmag = sbn < 0 ? -sbn : sbn;
        bdm  = sbd < 0 ? -sbd : sbd;
        r = '{num: '0, den: '0, ord: rau_pkg::ORD_EQUAL, err: rau_pkg::ERR_NONE};
        uses_b = (op <= rau_pkg::KIND_DIV) || (op == rau_pkg::KIND_CMP);
        rneg = 1'b0;
        rn = 0;
        rd = 1;
        if (op == rau_pkg::KIND_NONE)
            return r;
        if (adm == 0 || (uses_b && bdm == 0))
        begin
            r.err = rau_pkg::ERR_ZDEN;
            return r;
        end
        if (op == rau_pkg::KIND_CMP)
        begin
            lhs = (aneg ? -$signed(amag) : $signed(amag)) * $signed(bdm);
            rhs = (bneg ? -$signed(bmag) : $signed(bmag)) * $signed(adm);
            r.ord = lhs < rhs ? rau_pkg::ORD_LESS :
                    (lhs > rhs ? rau_pkg::ORD_GREATER : rau_pkg::ORD_EQUAL);
            return r;
        end
        if (op == rau_pkg::KIND_DIV && bmag == 0)
        begin
            r.err = rau_pkg::ERR_ZDEN;
            return r;
        end
        case (op)
            rau_pkg::KIND_ADD, rau_pkg::KIND_SUB:
            begin
                p = amag * bdm;
                q = bmag * adm;
                qneg = (op == rau_pkg::KIND_SUB) ? !bneg : bneg;
                if (aneg == qneg)
                begin
                    rneg = aneg;
                    rn = p + q;
                end
                else if (p >= q)
                begin
                    rneg = aneg;
                    rn = p - q;
                end
                else
                begin
                    rneg = qneg;
                    rn = q - p;
                end
                rd = adm * bdm;
            end
            rau_pkg::KIND_MUL:
            begin
                rneg = aneg != bneg;
                rn = amag * bmag;
                rd = adm * bdm;
            end
            rau_pkg::KIND_DIV:
            begin
                rneg = aneg != bneg;
                rn = amag * bdm;
                rd = adm * bmag;
            end
            rau_pkg::KIND_NEG:
            begin
                rneg = !aneg;
                rn = amag;
                rd = adm;
            end
            default:
            begin
                // increment: a + den/den
                if (!aneg)
                begin
                    rn = amag + adm;
                end
                else if (amag >= adm)
                begin
                    rneg = 1'b1;
                    rn = amag - adm;
                end
                else
                begin
                    rn = adm - amag;
                end
                rd = adm;
            end
        endcase
        g = gcd_mag(rn, rd);
        if (g != 0)
        begin
            rn = rn / g;
            rd = rd / g;
        end
        if (rn == 0)
        begin
            rneg = 1'b0;
            rd = 1;
        end
        if ((rneg ? rn > 64'h8000_0000 : rn > 64'h7FFF_FFFF) || rd > 64'h7FFF_FFFF)
        begin
            r.err = rau_pkg::ERR_OVF;
            return r;
        end
        r.num = rneg ? 32'(-rn) : rn[31:0];
        r.den = rd[30:0];
        return r;
    endfunction

    // Directed table: extremes, every kind, zero denominators, overflow, zero result
    function automatic stim_row_t row(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                      logic [31:0] bn, logic [31:0] bd, bit typed,
                                      logic [31:0] en, logic [30:0] ed,
                                      logic [1:0] eo, logic [1:0] ee);
        stim_row_t s;
        s.op = op; s.an = an; s.ad = ad; s.bn = bn; s.bd = bd; s.typed = typed;
        s.res = '{num: en, den: ed, ord: eo, err: ee};
        return s;
    endfunction

    stim_row_t directed_rows[$];

    initial
    begin
        directed_rows.push_back(row(rau_pkg::KIND_ADD, 1, 2, 1, 3, 1, 5, 6,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_SUB, 1, 2, 1, 2, 1, 0, 1,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_MUL, 2, 3, 3, 4, 1, 1, 2,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_DIV, 1, 2, 1, 4, 1, 2, 1,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_NEG, 3, -4, 7, 0, 1, 3, 4,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_INC, -1, 2, 0, 0, 1, 1, 2,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_CMP, 1, 3, 1, 2, 1, 0, 0,
                                    rau_pkg::ORD_LESS, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_CMP, 2, 4, -1, -2, 1, 0, 0,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_CMP, -1, -1, 0, 5, 1, 0, 0,
                                    rau_pkg::ORD_GREATER, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_ADD, 1, 0, 1, 1, 1, 0, 0,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_ZDEN));
        directed_rows.push_back(row(rau_pkg::KIND_CMP, 1, 1, 1, 0, 1, 0, 0,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_ZDEN));
        directed_rows.push_back(row(rau_pkg::KIND_DIV, 1, 1, 0, 5, 1, 0, 0,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_ZDEN));
        directed_rows.push_back(row(rau_pkg::KIND_NONE, 5, 0, 6, 0, 1, 0, 0,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_NEG, 32'h8000_0000, 1, 0, 0, 1,
                                    0, 0, rau_pkg::ORD_EQUAL, rau_pkg::ERR_OVF));
        directed_rows.push_back(row(rau_pkg::KIND_INC, 32'h7FFF_FFFF, 1, 0, 0, 1,
                                    0, 0, rau_pkg::ORD_EQUAL, rau_pkg::ERR_OVF));
        directed_rows.push_back(row(rau_pkg::KIND_NEG, 0, -7, 0, 0, 1, 0, 1,
                                    rau_pkg::ORD_EQUAL, rau_pkg::ERR_NONE));
        directed_rows.push_back(row(rau_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(rau_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                                    32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(rau_pkg::KIND_DIV, 32'hFFFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(rau_pkg::KIND_CMP, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
        directed_rows.push_back(row(rau_pkg::KIND_SUB, 32'h8000_0000, 3, 32'h7FFF_FFFF, 3,
                                    0, 0, 0, 0, 0));
        directed_rows.push_back(row(rau_pkg::KIND_INC, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0,
                                    0, 0, 0, 0, 0));
    end

    // Random operand: mostly small values so results stay in range, some extremes
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                            ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF);
            2, 3:    return 32'($signed($urandom_range(0, 131070)) - 65535);
            4:       return 32'($urandom_range(0, 2) - 1);
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic issue_item(stim_row_t s);
        frac_result_t predicted;
        int gap;
        gap = $urandom_range(0, 9) < 6 ? 0 :
              ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300) : $urandom_range(1, 4));
        predicted = compute_fraction(s.op, s.an, s.ad, s.bn, s.bd);
        if (s.typed && predicted != s.res)
        begin
            $display("%0t table row disagrees with prediction: table %p predicted %p",
                     $time, s.res, predicted);
            fail_count++;
        end
        // drop start only when an idle gap follows
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        kind  <= s.op;
        a_num <= s.an;
        a_den <= s.ad;
        b_num <= s.bn;
        b_den <= s.bd;
        // hold the item until it is taken
        do @(posedge clk); while (busy);
        pending_results.push_back(s.typed ? s.res : predicted);
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        frac_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: num %h den %h order %b error %0d",
                         $time, res_num, res_den, order, error);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_num !== want.num || res_den !== want.den ||
                    order !== want.ord || error !== want.err)
                begin
                    $display("%0t mismatch: expected num %h den %h order %b error %0d,",
                             $time, want.num, want.den, want.ord, want.err);
                    $display("    actual num %h den %h order %b error %0d",
                             res_num, res_den, order, error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        stim_row_t s;
        int n;
        fail_count = 0;
        cycle_count = 0;
        stim_done = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = rau_pkg::KIND_ADD;
        a_num = '0;
        a_den = '0;
        b_num = '0;
        b_den = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            issue_item(directed_rows[i]);
        for (n = 0; n < 1030; n++)
        begin
            s.op = $urandom_range(0, 19) == 0 ? rau_pkg::KIND_NONE :
                   3'($urandom_range(0, 6));
            s.an = rand_operand();
            s.ad = rand_operand();
            s.bn = rand_operand();
            s.bd = rand_operand();
            s.typed = 1'b0;
            issue_item(s);
        end
        start <= 1'b0;
        stim_done = 1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
